// File: hw/rtl/sls_pkg.sv
// Package: shared widths, register indexes, reset values, enable bits and state codes of the sequencer.
`timescale 1ns / 1ps

package sls_pkg;

  localparam int COUNT_WIDTH = 20;
  localparam int CFG_WIDTH   = 20;
  localparam int VIN_WIDTH   = 20;
  localparam int CODE_WIDTH  = 3;
  localparam int IDX_WIDTH   = 3;
  localparam int EN_WIDTH    = 3;
  // compare width covers both the counter and a time register
  localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

  // configuration register indexes
  localparam logic [IDX_WIDTH-1:0] REG_VIN_THRESHOLD    = 3'd0;
  localparam logic [IDX_WIDTH-1:0] REG_STARTUP_HOLD_MS  = 3'd1;
  localparam logic [IDX_WIDTH-1:0] REG_LOW_CONFIRM_MS   = 3'd2;
  localparam logic [IDX_WIDTH-1:0] REG_HOST_OFF_WAIT_MS = 3'd3;
  localparam logic [IDX_WIDTH-1:0] REG_LOW_HOLD_MS      = 3'd4;
  localparam logic [IDX_WIDTH-1:0] REG_SHUTDOWN_STEP_MS = 3'd5;

  // reset values
  localparam logic signed [CFG_WIDTH-1:0] VIN_THRESHOLD_RST = 20'sd20480; // 10.0 V in Q11
  localparam logic [CFG_WIDTH-1:0] STARTUP_HOLD_RST  = 20'd5000;
  localparam logic [CFG_WIDTH-1:0] LOW_CONFIRM_RST   = 20'd1000;
  localparam logic [CFG_WIDTH-1:0] HOST_OFF_WAIT_RST = 20'd15000;
  localparam logic [CFG_WIDTH-1:0] LOW_HOLD_RST      = 20'd60000;
  localparam logic [CFG_WIDTH-1:0] SHUTDOWN_STEP_RST = 20'd1000;

  // enable bit positions
  localparam int EN_BAT = 0;
  localparam int EN_RUN = 1;
  localparam int EN_SUP = 2;

  localparam logic [EN_WIDTH-1:0] EN_NONE = 3'b000;
  localparam logic [EN_WIDTH-1:0] EN_ALL  = 3'b111;
  localparam logic [EN_WIDTH-1:0] EN_BS   = 3'b101;
  localparam logic [EN_WIDTH-1:0] EN_B    = 3'b001;

  // external state codes
  localparam logic [CODE_WIDTH-1:0] CODE_INIT      = 3'd0;
  localparam logic [CODE_WIDTH-1:0] CODE_RUN       = 3'd1;
  localparam logic [CODE_WIDTH-1:0] CODE_CONFIRM   = 3'd2;
  localparam logic [CODE_WIDTH-1:0] CODE_HOST_WAIT = 3'd3;
  localparam logic [CODE_WIDTH-1:0] CODE_LOW_HOLD  = 3'd4;
  localparam logic [CODE_WIDTH-1:0] CODE_SHDN1     = 3'd5;
  localparam logic [CODE_WIDTH-1:0] CODE_SHDN2     = 3'd6;
  localparam logic [CODE_WIDTH-1:0] CODE_SHDN3     = 3'd7;

  typedef enum logic [7:0] {
    ST_INIT      = 8'b0000_0001,
    ST_RUN       = 8'b0000_0010,
    ST_CONFIRM   = 8'b0000_0100,
    ST_HOST_WAIT = 8'b0000_1000,
    ST_LOW_HOLD  = 8'b0001_0000,
    ST_SHDN1     = 8'b0010_0000,
    ST_SHDN2     = 8'b0100_0000,
    ST_SHDN3     = 8'b1000_0000
  } seq_state_t;

  function automatic logic [CODE_WIDTH-1:0] state_code(input seq_state_t st);
    logic [CODE_WIDTH-1:0] c;
    unique case (st)
      ST_INIT:      c = CODE_INIT;
      ST_RUN:       c = CODE_RUN;
      ST_CONFIRM:   c = CODE_CONFIRM;
      ST_HOST_WAIT: c = CODE_HOST_WAIT;
      ST_LOW_HOLD:  c = CODE_LOW_HOLD;
      ST_SHDN1:     c = CODE_SHDN1;
      ST_SHDN2:     c = CODE_SHDN2;
      ST_SHDN3:     c = CODE_SHDN3;
      default:      c = CODE_INIT;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/sls_if.sv
// Interfaces: sample input channel and result output channel of the sequencer.
`timescale 1ns / 1ps

interface sls_in_if import sls_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic                        ms_tick;
  logic signed [VIN_WIDTH-1:0] vin_sample;
  logic                        host_busy;

  modport source (output valid, output ms_tick, output vin_sample, output host_busy,
                  input ready);
  modport sink (input valid, input ms_tick, input vin_sample, input host_busy,
                output ready);
endinterface

interface sls_out_if import sls_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  battery_enable;
  logic                  host_run;
  logic                  host_supply_enable;
  logic                  low_vin_flag;
  logic [CODE_WIDTH-1:0] seq_state;

  modport source (output valid, output battery_enable, output host_run,
                  output host_supply_enable, output low_vin_flag, output seq_state,
                  input ready);
  modport sink (input valid, input battery_enable, input host_run,
                input host_supply_enable, input low_vin_flag, input seq_state,
                output ready);
endinterface

// File: hw/rtl/supply_loss_power_sequencer_unit.sv
// Top level: supply-loss power sequencer with registered enables and result register.
//
//   channel   dir  payload                                                handshake
//   in_ch     in   ms_tick, vin_sample (Q11), host_busy                   valid/ready
//   out_ch    out  battery_enable, host_run, host_supply_enable,
//                  low_vin_flag, seq_state                                valid/ready
//   cfg       in   cfg_index (3 bit), cfg_data (20 bit)                   cfg_write strobe
//
// One transaction per cycle: the state update is a single compare-and-count step
// between the state registers and the result register, so a result is ready in the
// cycle after its sample is taken. Reset (rst, synchronous) puts the sequencer in
// init with all enables off and loads the default register values. While a result
// waits on a stalled sink a new sample is still taken if the sink takes the held
// result in the same cycle; otherwise in_ch.ready drops until it does.
`timescale 1ns / 1ps

module supply_loss_power_sequencer_unit import sls_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  sls_in_if.sink               in_ch,
  sls_out_if.source            out_ch,
  input  logic                 cfg_write,
  input  logic [IDX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // configuration registers
  logic signed [CFG_WIDTH-1:0] vin_threshold;
  logic [CFG_WIDTH-1:0]        startup_hold_ms;
  logic [CFG_WIDTH-1:0]        low_confirm_ms;
  logic [CFG_WIDTH-1:0]        host_off_wait_ms;
  logic [CFG_WIDTH-1:0]        low_hold_ms;
  logic [CFG_WIDTH-1:0]        shutdown_step_ms;

  // sequencer state
  seq_state_t           state, state_next;
  logic [COUNT_WIDTH-1:0] elapsed_ms, elapsed_ms_next;
  logic [EN_WIDTH-1:0]  enables, enables_next;

  // result register
  logic                  out_valid;
  logic [EN_WIDTH-1:0]   out_enables;
  logic                  out_low_vin;
  logic [CODE_WIDTH-1:0] out_code;

  logic                  accept;
  logic                  low, good;
  logic [COUNT_WIDTH-1:0] counted;
  logic [CMP_WIDTH-1:0]  cnt_cmp;
  logic [CODE_WIDTH-1:0] code_next;

  // take a sample when the result slot is empty or is being emptied now
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      vin_threshold    <= VIN_THRESHOLD_RST;
      startup_hold_ms  <= STARTUP_HOLD_RST;
      low_confirm_ms   <= LOW_CONFIRM_RST;
      host_off_wait_ms <= HOST_OFF_WAIT_RST;
      low_hold_ms      <= LOW_HOLD_RST;
      shutdown_step_ms <= SHUTDOWN_STEP_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_VIN_THRESHOLD:    vin_threshold    <= $signed(cfg_data);
        REG_STARTUP_HOLD_MS:  startup_hold_ms  <= cfg_data;
        REG_LOW_CONFIRM_MS:   low_confirm_ms   <= cfg_data;
        REG_HOST_OFF_WAIT_MS: host_off_wait_ms <= cfg_data;
        REG_LOW_HOLD_MS:      low_hold_ms      <= cfg_data;
        REG_SHUTDOWN_STEP_MS: shutdown_step_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // strict compares: a sample equal to the threshold is neither low nor good
  assign low  = in_ch.vin_sample < vin_threshold;
  assign good = in_ch.vin_sample > vin_threshold;

  // count the tick first, saturating at full scale
  assign counted = (in_ch.ms_tick && (elapsed_ms != COUNT_MAX)) ?
                   elapsed_ms + COUNT_WIDTH'(1) : elapsed_ms;
  assign cnt_cmp = CMP_WIDTH'(counted);

  always_comb begin
    state_next      = state;
    elapsed_ms_next = counted;
    enables_next    = enables;
    unique case (state)
      ST_INIT: begin
        enables_next = EN_NONE;
        if (low) begin
          elapsed_ms_next = '0;
        end else if (cnt_cmp > CMP_WIDTH'(startup_hold_ms)) begin
          enables_next = EN_ALL;
          state_next   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (low) begin
          elapsed_ms_next = '0;
          state_next      = ST_CONFIRM;
        end
      end
      ST_CONFIRM: begin
        // return to run keeps the count running
        if (good) begin
          state_next = ST_RUN;
        end else if (cnt_cmp > CMP_WIDTH'(low_confirm_ms)) begin
          elapsed_ms_next = '0;
          enables_next    = EN_BS;
          state_next      = ST_HOST_WAIT;
        end
      end
      ST_HOST_WAIT: begin
        if (cnt_cmp > CMP_WIDTH'(host_off_wait_ms)) begin
          elapsed_ms_next = '0;
          enables_next    = EN_B;
          state_next      = ST_LOW_HOLD;
        end
      end
      ST_LOW_HOLD: begin
        // supply back: restart qualification, enables hold until init clears them
        if (good) begin
          elapsed_ms_next = '0;
          state_next      = ST_INIT;
        end else if (cnt_cmp > CMP_WIDTH'(low_hold_ms)) begin
          elapsed_ms_next = '0;
          enables_next    = EN_B;
          state_next      = ST_SHDN1;
        end
      end
      ST_SHDN1: begin
        // a busy host holds the first step
        if ((cnt_cmp > CMP_WIDTH'(shutdown_step_ms)) && !in_ch.host_busy) begin
          elapsed_ms_next = '0;
          enables_next    = EN_B;
          state_next      = ST_SHDN2;
        end
      end
      ST_SHDN2: begin
        if (cnt_cmp > CMP_WIDTH'(shutdown_step_ms)) begin
          elapsed_ms_next = '0;
          enables_next    = EN_NONE;
          state_next      = ST_SHDN3;
        end
      end
      ST_SHDN3: begin
        enables_next = EN_NONE;
        if (cnt_cmp > CMP_WIDTH'(shutdown_step_ms)) begin
          elapsed_ms_next = '0;
          state_next      = ST_INIT;
        end
      end
      default: begin
        elapsed_ms_next = '0;
        enables_next    = EN_NONE;
        state_next      = ST_INIT;
      end
    endcase
  end

  assign code_next = state_code(state_next);

  // advance the sequencer only on an accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      elapsed_ms <= '0;
      enables    <= EN_NONE;
    end else if (accept) begin
      state      <= state_next;
      elapsed_ms <= elapsed_ms_next;
      enables    <= enables_next;
    end
  end

  // result register: load on accept, drop valid once the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_enables <= enables_next;
      out_low_vin <= (code_next > CODE_RUN);
      out_code    <= code_next;
    end
  end

  assign out_ch.valid              = out_valid;
  assign out_ch.battery_enable     = out_enables[EN_BAT];
  assign out_ch.host_run           = out_enables[EN_RUN];
  assign out_ch.host_supply_enable = out_enables[EN_SUP];
  assign out_ch.low_vin_flag       = out_low_vin;
  assign out_ch.seq_state          = out_code;

  // a held result blocks new samples
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("sample taken while a result is stalled");

  // every accepted sample yields a result on the next cycle
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted sample produced no result");

  // host run is only requested with battery and host supply on
  a_run_needs_supply: assert property (@(posedge clk) disable iff (rst)
    enables[EN_RUN] |-> (enables[EN_SUP] && enables[EN_BAT]))
    else $error("host run without supply and battery");

  // running state always has everything enabled
  a_run_all_enabled: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (enables == EN_ALL))
    else $error("running with enables off");

endmodule

// File: tb/sv/supply_loss_power_sequencer_unit_test.sv
// Self-checking testbench for the supply-loss power sequencer: predicts and checks each status.
`timescale 1ns / 1ps

module supply_loss_power_sequencer_unit_test import sls_pkg::*;;

  // cycles with no transaction on either channel before the run is declared hung
  localparam int WATCHDOG_LIMIT = 4000;
  // quiet time after the last status: covers the result register, plus margin
  localparam int SETTLE_CYCLES  = 4;
  localparam int VIN_MIN = -(1 << (VIN_WIDTH - 1));
  localparam int VIN_MAX = (1 << (VIN_WIDTH - 1)) - 1;
  localparam logic [CFG_WIDTH-1:0] TIME_MAX = '1;
  localparam int LONG_STALL_CYCLES = 200;

  // one status transaction as the sequencer reports it
  typedef struct packed {
    logic                  bat;
    logic                  run;
    logic                  sup;
    logic                  low_flag;
    logic [CODE_WIDTH-1:0] code;
  } seq_status_t;

  // where a sample sits relative to the threshold
  typedef enum {VIN_LOW, VIN_GOOD, VIN_EQUAL, VIN_ANY} vin_class_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [IDX_WIDTH-1:0] cfg_index;
  logic [CFG_WIDTH-1:0] cfg_data;

  sls_in_if  in_ch ();
  sls_out_if out_ch ();

  supply_loss_power_sequencer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predicted configuration and sequencer state
  logic signed [CFG_WIDTH-1:0] thr_q;
  logic [CFG_WIDTH-1:0]        startup_hold_q;
  logic [CFG_WIDTH-1:0]        low_confirm_q;
  logic [CFG_WIDTH-1:0]        host_off_wait_q;
  logic [CFG_WIDTH-1:0]        low_hold_q;
  logic [CFG_WIDTH-1:0]        step_q;
  logic [CODE_WIDTH-1:0]       state_q;
  logic [COUNT_WIDTH-1:0]      elapsed_q;
  logic [EN_WIDTH-1:0]         enables_q;

  // statuses predicted for accepted samples, oldest first
  seq_status_t expected_status_q[$];

  int send_gap_pct;
  int take_gap_pct;
  int hold_request;
  int hold_left;
  int error_count;
  int quiet_cycles;

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // move to a new state: clear the timer and load the enables
  function automatic void enter_state(input logic [CODE_WIDTH-1:0] code,
                                      input logic [EN_WIDTH-1:0] en);
    elapsed_q = '0;
    enables_q = en;
    state_q   = code;
  endfunction

  // apply one sample to the predicted sequencer and return the status it reports
  function automatic seq_status_t advance_sequencer(input logic tick,
                                                    input logic signed [VIN_WIDTH-1:0] vin,
                                                    input logic busy);
    seq_status_t st;
    logic        vin_low;
    logic        vin_good;
    // strict compares: a sample equal to the threshold is neither low nor good
    vin_low  = vin < thr_q;
    vin_good = vin > thr_q;
    // count the tick first; the counter saturates
    if (tick && elapsed_q != '1) elapsed_q = elapsed_q + COUNT_WIDTH'(1);
    case (state_q)
      CODE_INIT: begin
        enables_q = EN_NONE;
        if (vin_low) begin
          elapsed_q = '0;
        end else if (elapsed_q > startup_hold_q) begin
          enables_q = EN_ALL;
          state_q   = CODE_RUN;
        end
      end
      CODE_RUN: begin
        if (vin_low) begin
          elapsed_q = '0;
          state_q   = CODE_CONFIRM;
        end
      end
      CODE_CONFIRM: begin
        // a return to running keeps the timer
        if (vin_good) state_q = CODE_RUN;
        else if (elapsed_q > low_confirm_q) enter_state(CODE_HOST_WAIT, EN_BS);
      end
      CODE_HOST_WAIT: begin
        if (elapsed_q > host_off_wait_q) enter_state(CODE_LOW_HOLD, EN_B);
      end
      CODE_LOW_HOLD: begin
        // supply back: restart qualification but leave the enables for init to clear
        if (vin_good) begin
          elapsed_q = '0;
          state_q   = CODE_INIT;
        end else if (elapsed_q > low_hold_q) begin
          enter_state(CODE_SHDN1, EN_B);
        end
      end
      CODE_SHDN1: begin
        if (elapsed_q > step_q && !busy) enter_state(CODE_SHDN2, EN_B);
      end
      CODE_SHDN2: begin
        if (elapsed_q > step_q) enter_state(CODE_SHDN3, EN_NONE);
      end
      default: begin
        enables_q = EN_NONE;
        if (elapsed_q > step_q) enter_state(CODE_INIT, EN_NONE);
      end
    endcase
    st.bat      = enables_q[EN_BAT];
    st.run      = enables_q[EN_RUN];
    st.sup      = enables_q[EN_SUP];
    st.low_flag = state_q > CODE_RUN;
    st.code     = state_q;
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // offer one sample, wait for its transaction and predict its status
  task automatic send_sample(input logic tick, input logic signed [VIN_WIDTH-1:0] vin,
                             input logic busy);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.ms_tick    <= tick;
    in_ch.vin_sample <= vin;
    in_ch.host_busy  <= busy;
    do @(posedge clk); while (!in_ch.ready);
    expected_status_q.push_back(advance_sequencer(tick, vin, busy));
    @(negedge clk);
  endtask

  // drop valid and hold until every predicted status has been seen
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_status_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic put_reg(input logic [IDX_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
  endtask

  // write all six registers once the sequencer has gone quiet
  task automatic write_config(input logic signed [CFG_WIDTH-1:0] thr,
                              input logic [CFG_WIDTH-1:0] startup,
                              input logic [CFG_WIDTH-1:0] confirm,
                              input logic [CFG_WIDTH-1:0] host_wait,
                              input logic [CFG_WIDTH-1:0] hold,
                              input logic [CFG_WIDTH-1:0] step);
    wait_idle();
    put_reg(REG_VIN_THRESHOLD, thr);
    put_reg(REG_STARTUP_HOLD_MS, startup);
    put_reg(REG_LOW_CONFIRM_MS, confirm);
    put_reg(REG_HOST_OFF_WAIT_MS, host_wait);
    put_reg(REG_LOW_HOLD_MS, hold);
    put_reg(REG_SHUTDOWN_STEP_MS, step);
    cfg_write <= 1'b0;
    @(negedge clk);
    thr_q           = thr;
    startup_hold_q  = startup;
    low_confirm_q   = confirm;
    host_off_wait_q = host_wait;
    low_hold_q      = hold;
    step_q          = step;
  endtask

  // pick a sample of the given class relative to the current threshold
  function automatic logic signed [VIN_WIDTH-1:0] pick_vin(input vin_class_t kind);
    int t;
    int v;
    int span;
    t = int'(thr_q);
    v = t;
    case (kind)
      VIN_LOW: begin
        // nothing lies below the most negative threshold: fall back to equal
        if (t > VIN_MIN) begin
          span = (t - VIN_MIN > 64) ? 64 : t - VIN_MIN;
          if ($urandom_range(1)) v = t - int'($urandom_range(span, 1));
          else v = VIN_MIN + int'($urandom_range(t - 1 - VIN_MIN));
        end
      end
      VIN_GOOD: begin
        if (t < VIN_MAX) begin
          span = (VIN_MAX - t > 64) ? 64 : VIN_MAX - t;
          if ($urandom_range(1)) v = t + int'($urandom_range(span, 1));
          else v = t + 1 + int'($urandom_range(VIN_MAX - t - 1));
        end
      end
      VIN_ANY: v = $urandom;
      default: v = t;
    endcase
    return v[VIN_WIDTH-1:0];
  endfunction

  // mostly short times so that every state is reached; now and then a longer one
  function automatic logic [CFG_WIDTH-1:0] pick_time();
    if ($urandom_range(9) == 0) return CFG_WIDTH'($urandom_range(40));
    return CFG_WIDTH'($urandom_range(6));
  endfunction

  // runs of samples of one voltage class, so that the low-voltage sequence goes deep
  task automatic random_walk(input int n_items, input int max_run);
    int         sent;
    int         run_len;
    int         pick;
    int         tick_pct;
    int         busy_pct;
    vin_class_t kind;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 40) kind = VIN_GOOD;
      else if (pick < 75) kind = VIN_LOW;
      else if (pick < 85) kind = VIN_EQUAL;
      else kind = VIN_ANY;
      run_len  = $urandom_range(max_run, 1);
      tick_pct = $urandom_range(100, 30);
      busy_pct = $urandom_range(100);
      repeat (run_len) begin
        send_sample($urandom_range(99) < tick_pct, pick_vin(kind),
                    $urandom_range(99) < busy_pct);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready pattern, checking, watchdog
  // ---------------------------------------------------------------------------

  // drive ready: random gaps, or a long hold-off when one is requested
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= take_gap_pct);
      end
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // compare each status transaction with the oldest prediction
  always @(posedge clk) begin
    seq_status_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_status_q.size() == 0) begin
        $error("status transaction with none expected (seq_state %0d)", out_ch.seq_state);
        error_count++;
      end else begin
        want = expected_status_q.pop_front();
        check_field("battery_enable", 8'(want.bat), 8'(out_ch.battery_enable));
        check_field("host_run", 8'(want.run), 8'(out_ch.host_run));
        check_field("host_supply_enable", 8'(want.sup), 8'(out_ch.host_supply_enable));
        check_field("low_vin_flag", 8'(want.low_flag), 8'(out_ch.low_vin_flag));
        check_field("seq_state", 8'(want.code), 8'(out_ch.seq_state));
      end
    end
  end

  // end the run if neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("supply_loss_power_sequencer_unit_test: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset values: 10 V threshold and a 5 s startup hold keep the sequencer in init
  task automatic test_reset_defaults();
    send_sample(1'b1, VIN_WIDTH'(20480), 1'b0);  // on the threshold: keep counting
    send_sample(1'b1, VIN_WIDTH'(20479), 1'b1);  // just below: restart
    send_sample(1'b1, VIN_WIDTH'(20481), 1'b0);  // just above
  endtask

  // walk every state with zero times and a threshold of zero
  task automatic test_directed_walk();
    write_config('0, '0, '0, '0, '0, '0);
    send_sample(1'b1, VIN_WIDTH'(VIN_MAX), 1'b0);  // init -> run, all enabled
    send_sample(1'b1, '0, 1'b0);                   // equal: stay running
    send_sample(1'b0, VIN_WIDTH'(VIN_MIN), 1'b0);  // low: confirm
    send_sample(1'b0, VIN_WIDTH'(1), 1'b0);        // good: back to run, timer kept
    send_sample(1'b0, VIN_WIDTH'(-1), 1'b0);       // confirm again
    send_sample(1'b1, VIN_WIDTH'(-1), 1'b0);       // -> host wait
    send_sample(1'b1, '0, 1'b1);                   // -> low hold
    send_sample(1'b0, VIN_WIDTH'(5), 1'b0);        // supply back: init, enables kept
    send_sample(1'b0, VIN_WIDTH'(-5), 1'b0);       // init clears the enables
    send_sample(1'b1, VIN_WIDTH'(5), 1'b0);        // -> run
    send_sample(1'b0, VIN_WIDTH'(-5), 1'b0);       // -> confirm
    send_sample(1'b1, VIN_WIDTH'(-5), 1'b0);       // -> host wait
    send_sample(1'b1, VIN_WIDTH'(-5), 1'b0);       // -> low hold
    send_sample(1'b1, '0, 1'b0);                   // equal does not return: step one
    send_sample(1'b1, VIN_WIDTH'(7), 1'b1);        // host busy: stay in step one
    send_sample(1'b1, VIN_WIDTH'(7), 1'b0);        // -> step two
    send_sample(1'b1, VIN_WIDTH'(-7), 1'b0);       // -> step three
    send_sample(1'b0, VIN_WIDTH'(-7), 1'b0);       // no tick: stay
    send_sample(1'b1, VIN_WIDTH'(7), 1'b1);        // -> init
  endtask

  // threshold and time registers at their limits
  task automatic test_config_extremes();
    // lowest threshold: no sample is ever low
    write_config(CFG_WIDTH'(VIN_MIN), pick_time(), pick_time(), pick_time(), pick_time(),
                 pick_time());
    random_walk(40, 12);
    // highest threshold: no sample is ever good
    write_config(CFG_WIDTH'(VIN_MAX), '0, '0, pick_time(), pick_time(), '0);
    random_walk(40, 12);
    // the counter can never exceed the largest time
    write_config(CFG_WIDTH'($urandom), TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX);
    random_walk(40, 12);
    write_config('0, '0, '0, TIME_MAX, TIME_MAX, TIME_MAX);
    random_walk(40, 12);
    write_config('0, '0, '0, '0, '0, TIME_MAX);
    random_walk(40, 12);
  endtask

  // random traffic in chunks, each with a fresh configuration
  task automatic test_random_traffic(input int send_gap, input int take_gap, input int n_items);
    int done_items;
    send_gap_pct = send_gap;
    take_gap_pct = take_gap;
    done_items   = 0;
    while (done_items < n_items) begin
      write_config(CFG_WIDTH'($urandom), pick_time(), pick_time(), pick_time(), pick_time(),
                   pick_time());
      random_walk(120, 32);
      done_items += 120;
    end
  endtask

  // stall the result side long enough to back up the input, then drain fully
  task automatic test_backpressure();
    send_gap_pct = 0;
    take_gap_pct = 0;
    write_config(CFG_WIDTH'($urandom), pick_time(), pick_time(), pick_time(), pick_time(),
                 pick_time());
    hold_request = LONG_STALL_CYCLES;
    random_walk(40, 8);
    wait_idle();
    random_walk(20, 8);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.ms_tick    = 1'b0;
    in_ch.vin_sample = '0;
    in_ch.host_busy  = 1'b0;
    send_gap_pct     = 11;
    take_gap_pct     = 84;
    hold_request     = 0;
    hold_left        = 0;
    error_count      = 0;
    quiet_cycles     = 0;
    // predicted state after reset
    thr_q            = VIN_THRESHOLD_RST;
    startup_hold_q   = STARTUP_HOLD_RST;
    low_confirm_q    = LOW_CONFIRM_RST;
    host_off_wait_q  = HOST_OFF_WAIT_RST;
    low_hold_q       = LOW_HOLD_RST;
    step_q           = SHUTDOWN_STEP_RST;
    state_q          = CODE_INIT;
    elapsed_q        = '0;
    enables_q        = EN_NONE;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_directed_walk();
    test_config_extremes();
    test_random_traffic(11, 84, 480);
    test_random_traffic(84, 11, 480);
    test_random_traffic(0, 0, 600);
    test_backpressure();

    // hold until every status is in, then allow a few quiet cycles for strays
    wait_idle();
    if (error_count == 0) begin
      $display("supply_loss_power_sequencer_unit_test: done, clean");
    end else begin
      $display("supply_loss_power_sequencer_unit_test: done, errors");
    end
    $finish;
  end

endmodule
